/* src/lrudc_pkg.sv */
// ----------------------------------------------------------------------------
// lrudc_pkg
// Shared types, codes and defaults of the LRU digest cache index.
// ----------------------------------------------------------------------------
package lrudc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int DIG_W       = 64;
	localparam int ACT_W       = 2;
	localparam int LIMIT_W     = 5;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;

	localparam logic REG_LIMIT    = 1'b0;
	localparam logic REG_WRITABLE = 1'b1;

	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_INSERT,
		OP_UPDATE,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_EXEC
	} eng_state_t;

	typedef struct packed {
		op_t              op;
		logic [DIG_W-1:0] key_hi;
		logic [DIG_W-1:0] key_lo;
		logic [DIG_W-1:0] val_hi;
		logic [DIG_W-1:0] val_lo;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [DIG_W-1:0] found_hi;
		logic [DIG_W-1:0] found_lo;
		logic             evicted;
		logic [DIG_W-1:0] ev_key_hi;
		logic [DIG_W-1:0] ev_key_lo;
		logic             ignored;
	} res_t;

endpackage

/* src/lrudc_front.sv */
// ----------------------------------------------------------------------------
// lrudc_front
// Accepts items, decodes the action and queues them for the back engine.
// ----------------------------------------------------------------------------
module lrudc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [lrudc_pkg::ACT_W-1:0]  action,
	input  logic [lrudc_pkg::DIG_W-1:0]  key_hi,
	input  logic [lrudc_pkg::DIG_W-1:0]  key_lo,
	input  logic [lrudc_pkg::DIG_W-1:0]  value_hi,
	input  logic [lrudc_pkg::DIG_W-1:0]  value_lo,
	output logic                         req_valid,
	output lrudc_pkg::req_t              req,
	input  logic                         req_take
);
	import lrudc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	op_t              op_dec;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		case (action)
			ACT_LOOKUP: op_dec = OP_LOOKUP;
			ACT_INSERT: op_dec = OP_INSERT;
			ACT_UPDATE: op_dec = OP_UPDATE;
			default:    op_dec = OP_NONE;
		endcase
	end

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign req_valid = (cnt_q != '0);
	assign req       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= '{op: op_dec, key_hi: key_hi, key_lo: key_lo,
				val_hi: value_hi, val_lo: value_lo};
		end
	end

endmodule

/* src/lrudc_back.sv */
// ----------------------------------------------------------------------------
// lrudc_back
// Scans the entry store for one item, then applies lookup, insert or update
// and the recency changes, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lrudc_back #(
	parameter int ENTRIES = lrudc_pkg::ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	input  lrudc_pkg::req_t                      req,
	output logic                                 req_take,
	input  logic [$clog2(ENTRIES+1)-1:0]         limit,
	input  logic                                 writable,
	output lrudc_pkg::res_t                      res,
	output logic                                 res_valid,
	input  logic                                 res_pop,
	output logic [$clog2(ENTRIES+1)-1:0]         live_count
);
	import lrudc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int KEY_W = 2 * DIG_W;

	eng_state_t       state_q;
	eng_state_t       state_d;
	req_t             cur_q;
	logic             full_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             cmp_vld_s2;
	logic [IDX_W-1:0] cmp_idx_s2;
	logic [KEY_W-1:0] key_rd_s2;
	logic [KEY_W-1:0] val_rd_s2;

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [KEY_W-1:0] val_mem [ENTRIES];

	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   rank_q [ENTRIES];
	logic [CNT_W-1:0]   count_q;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] hit_rank_q;
	logic [KEY_W-1:0] found_q;
	logic [KEY_W-1:0] wkey_q;
	logic             ev_fnd_q;
	logic             free_fnd_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             res_valid_q;
	res_t             res_q;
	res_t             res_d;

	logic             load;
	logic             rd_en;
	logic             exec_go;
	logic [CNT_W-1:0] thr;
	logic             c_valid;
	logic [IDX_W-1:0] c_rank;
	logic             c_match;
	logic             c_evict;
	logic             c_worst;
	logic             c_free;
	logic             is_wr;
	logic             ins_new;
	logic             mtf;
	logic             val_we;
	logic [IDX_W-1:0] val_widx;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req.op == OP_NONE) ? ST_EXEC : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_idx_q == IDX_W'(ENTRIES - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_EXEC;
			ST_EXEC: begin
				if (exec_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_take = 1'b0;
		rd_en    = 1'b0;
		exec_go  = 1'b0;
		case (state_q)
			ST_IDLE: req_take = 1'b1;
			ST_SCAN: rd_en = 1'b1;
			ST_FIN:  rd_en = 1'b0;
			ST_EXEC: exec_go = !res_valid_q || res_pop;
			default: rd_en = 1'b0;
		endcase
	end

	assign load   = req_take && req_valid;
	assign thr    = limit - CNT_W'(1);

	assign c_valid = valid_q[cmp_idx_s2];
	assign c_rank  = rank_q[cmp_idx_s2];
	assign c_match = cmp_vld_s2 && c_valid && (key_rd_s2 == {cur_q.key_hi, cur_q.key_lo});
	assign c_evict = cmp_vld_s2 && c_valid && full_q && (CNT_W'(c_rank) >= thr);
	assign c_worst = c_evict && (!ev_fnd_q || (c_rank != '0));
	assign c_free  = cmp_vld_s2 && (!c_valid || (full_q && (CNT_W'(c_rank) >= thr)));

	assign is_wr    = (cur_q.op == OP_INSERT) || (cur_q.op == OP_UPDATE);
	assign ins_new  = (cur_q.op == OP_INSERT) && writable && !hit_q;
	assign mtf      = hit_q && ((cur_q.op == OP_LOOKUP) || ((cur_q.op == OP_INSERT) && writable));
	assign val_we   = exec_go && ((writable && hit_q && is_wr) || ins_new);
	assign val_widx = hit_q ? hit_idx_q : free_idx_q;

	always_comb begin
		res_d           = '0;
		res_d.hit       = hit_q;
		res_d.ignored   = is_wr && (!writable || ((cur_q.op == OP_UPDATE) && !hit_q));
		if ((cur_q.op == OP_LOOKUP) && hit_q) begin
			res_d.found_hi = found_q[KEY_W-1:DIG_W];
			res_d.found_lo = found_q[DIG_W-1:0];
		end
		if (ins_new && full_q) begin
			res_d.evicted   = 1'b1;
			res_d.ev_key_hi = wkey_q[KEY_W-1:DIG_W];
			res_d.ev_key_lo = wkey_q[DIG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			cmp_vld_s2  <= 1'b0;
			full_q      <= 1'b0;
			hit_q       <= 1'b0;
			ev_fnd_q    <= 1'b0;
			free_fnd_q  <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			for (int j = 0; j < ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			state_q    <= state_d;
			cmp_vld_s2 <= rd_en;
			if (load) begin
				rd_idx_q   <= '0;
				hit_q      <= 1'b0;
				ev_fnd_q   <= 1'b0;
				free_fnd_q <= 1'b0;
				full_q     <= (count_q >= limit);
			end else begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				if (c_match) begin
					hit_q <= 1'b1;
				end
				if (c_evict) begin
					ev_fnd_q <= 1'b1;
				end
				if (c_free) begin
					free_fnd_q <= 1'b1;
				end
			end
			if (exec_go) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			if (exec_go && mtf) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (IDX_W'(j) == hit_idx_q) begin
						rank_q[j] <= '0;
					end else if (valid_q[j] && (rank_q[j] < hit_rank_q)) begin
						rank_q[j] <= rank_q[j] + IDX_W'(1);
					end
				end
			end
			if (exec_go && ins_new) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (IDX_W'(j) == free_idx_q) begin
						valid_q[j] <= 1'b1;
						rank_q[j]  <= '0;
					end else if (full_q && valid_q[j] && (CNT_W'(rank_q[j]) >= thr)) begin
						valid_q[j] <= 1'b0;
						rank_q[j]  <= '0;
					end else if (valid_q[j]) begin
						rank_q[j] <= rank_q[j] + IDX_W'(1);
					end
				end
				count_q <= full_q ? limit : count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= req;
		end
		cmp_idx_s2 <= rd_idx_q;
		if (c_match) begin
			hit_idx_q  <= cmp_idx_s2;
			hit_rank_q <= c_rank;
			found_q    <= val_rd_s2;
		end
		if (c_worst) begin
			wkey_q <= key_rd_s2;
		end
		if (c_free && !free_fnd_q) begin
			free_idx_q <= cmp_idx_s2;
		end
		if (exec_go) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && ins_new) begin
			key_mem[free_idx_q] <= {cur_q.key_hi, cur_q.key_lo};
		end
		if (rd_en) begin
			key_rd_s2 <= key_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_widx] <= {cur_q.val_hi, cur_q.val_lo};
		end
		if (rd_en) begin
			val_rd_s2 <= val_mem[rd_idx_q];
		end
	end

	assign res        = res_q;
	assign res_valid  = res_valid_q;
	assign live_count = count_q;

endmodule

/* src/lru_digest_cache_index_core.sv */
// ----------------------------------------------------------------------------
// lru_digest_cache_index_core
// Fully associative LRU index of 128-bit key digests and value digests.
// ----------------------------------------------------------------------------
// Items enter a two-deep queue and are worked one at a time by an engine that
// reads the key and value stores through a single read port, one entry per
// cycle. A lookup, insert or update passes through the engine as load, a read
// of every entry, last compare and execute; an unused action code goes from
// load straight to execute. A finished result waits in an output register
// while the next item is scanned. No clearing pass is needed after reset.
module lru_digest_cache_index_core #(
	parameter int ENTRIES = lrudc_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lrudc_pkg::PADDR_W-1:0]  paddr,
	input  logic [lrudc_pkg::PDATA_W-1:0]  pwdata,
	output logic [lrudc_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  logic [lrudc_pkg::ACT_W-1:0]    action,
	input  logic [lrudc_pkg::DIG_W-1:0]    key_hi,
	input  logic [lrudc_pkg::DIG_W-1:0]    key_lo,
	input  logic [lrudc_pkg::DIG_W-1:0]    value_hi,
	input  logic [lrudc_pkg::DIG_W-1:0]    value_lo,
	output logic                           empty,
	input  logic                           pop,
	output logic                           hit,
	output logic [lrudc_pkg::DIG_W-1:0]    found_value_hi,
	output logic [lrudc_pkg::DIG_W-1:0]    found_value_lo,
	output logic                           evicted,
	output logic [lrudc_pkg::DIG_W-1:0]    evicted_key_hi,
	output logic [lrudc_pkg::DIG_W-1:0]    evicted_key_lo,
	output logic                           ignored
);
	import lrudc_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [LIMIT_W-1:0] limit_q;
	logic               writable_q;
	logic               cfg_wr;
	logic [CNT_W-1:0]   eff_limit;
	logic               req_valid;
	req_t               req;
	logic               req_take;
	res_t               res;
	logic               res_valid;
	logic [CNT_W-1:0]   live_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= '0;
			writable_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_LIMIT) begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end else begin
				writable_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_WRITABLE) ? PDATA_W'(writable_q) : PDATA_W'(limit_q);

	assign eff_limit = ((limit_q == '0) || (32'(limit_q) > ENTRIES)) ?
		CNT_W'(ENTRIES) : CNT_W'(limit_q);

	lrudc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.key_hi    (key_hi),
		.key_lo    (key_lo),
		.value_hi  (value_hi),
		.value_lo  (value_lo),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (req_take)
	);

	lrudc_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.req_take   (req_take),
		.limit      (eff_limit),
		.writable   (writable_q),
		.res        (res),
		.res_valid  (res_valid),
		.res_pop    (pop),
		.live_count (live_count)
	);

	assign empty          = !res_valid;
	assign hit            = res.hit;
	assign found_value_hi = res.found_hi;
	assign found_value_lo = res.found_lo;
	assign evicted        = res.evicted;
	assign evicted_key_hi = res.ev_key_hi;
	assign evicted_key_lo = res.ev_key_lo;
	assign ignored        = res.ignored;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_count) <= ENTRIES)
		else $error("live entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(live_count > $past(live_count)) |-> (live_count == $past(live_count) + CNT_W'(1)))
		else $error("live entry count grew by more than one");

	a_evict_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && evicted) |-> (!hit && !ignored))
		else $error("eviction reported on a hit or dropped item");

	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ignored) |-> (!evicted && (found_value_hi == '0) && (found_value_lo == '0)))
		else $error("dropped item reports a value or eviction");

endmodule
